// ----- hdl/prdo_pkg.sv -----
`default_nettype none
package prdo_pkg;

	localparam int unsigned DEPTH_DEF       = 16;
	localparam int unsigned MAX_BYTES_DEF   = 256;
	localparam int unsigned HEADER_DEF      = 8;
	localparam int unsigned COUNT_W         = 16;

	localparam logic [2:0] OP_ENQ_PKT = 3'd0;
	localparam logic [2:0] OP_ENQ_RAW = 3'd1;
	localparam logic [2:0] OP_DEQ     = 3'd2;
	localparam logic [2:0] OP_FIND    = 3'd3;
	localparam logic [2:0] OP_BEAT    = 3'd4;

	localparam logic [1:0] STAT_WORD     = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;

	typedef enum logic [1:0] {
		CMD_EMPTY,
		CMD_EMIT,
		CMD_FIND
	} cmd_kind_t;

	// Read request handed from the front to the back.
	typedef struct packed {
		cmd_kind_t            kind;
		logic [31:0]          seq;
		logic [COUNT_W-1:0]   base;
		logic [COUNT_W-1:0]   count;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] seq_out;
		logic [8:0]  size_out;
		logic [63:0] word_out;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

// ----- hdl/prdo_if.sv -----
`default_nettype none
interface pr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] seq;
	logic [9:0]  length;
	logic [63:0] data_word;

	modport source (output valid, operation, seq, length, data_word, input ready);
	modport sink (input valid, operation, seq, length, data_word, output ready);
endinterface

interface pr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] seq_out;
	logic [8:0]  size_out;
	logic [63:0] word_out;
	logic        last;

	modport source (output valid, status, seq_out, size_out, word_out, last, input ready);
	modport sink (input valid, status, seq_out, size_out, word_out, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/prdo_ram.sv -----
`default_nettype none
module prdo_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/prdo_cmd_fifo.sv -----
`default_nettype none
module prdo_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire prdo_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output logic               valid,
	output logic               full,
	output prdo_pkg::cmd_t     head_cmd
);
	import prdo_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign valid    = (cnt_q != 2'd0);
	assign full     = (cnt_q == 2'd2);
	assign head_cmd = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ----- hdl/prdo_front.sv -----
`default_nettype none
module prdo_front #(
	parameter int unsigned DEPTH            = prdo_pkg::DEPTH_DEF,
	parameter int unsigned MAX_PACKET_BYTES = prdo_pkg::MAX_BYTES_DEF,
	parameter int unsigned HEADER_BYTES     = prdo_pkg::HEADER_DEF,
	localparam int unsigned WPS             = (MAX_PACKET_BYTES + 7) / 8,
	localparam int unsigned SW              = $clog2(DEPTH),
	localparam int unsigned AW              = $clog2(DEPTH * WPS)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	pr_req_if.sink               req,
	input  wire logic            back_busy,
	input  wire logic            q_valid,
	input  wire logic            q_full,
	output logic                 q_push,
	output prdo_pkg::cmd_t       q_cmd,
	input  wire logic [SW-1:0]   rd_slot,
	output logic      [31:0]     rd_seq,
	output logic      [9:0]      rd_size,
	output logic                 ram_we,
	output logic      [AW-1:0]   ram_waddr,
	output logic      [63:0]     ram_wdata
);
	import prdo_pkg::*;

	logic [31:0]        seq_arr  [DEPTH];
	logic [9:0]         size_arr [DEPTH];
	logic [COUNT_W-1:0] head_q, tail_q;
	logic               fill_pending_q, fill_rejected_q;
	logic [7:0]         beats_left_q, off_q;
	logic [31:0]        pending_seq_q;
	logic [9:0]         pending_size_q;

	logic               take, is_open, is_beat, beat_ok, commit, full, empty;
	logic [COUNT_W-1:0] level;
	logic [10:0]        pkt_sum;
	logic [9:0]         open_size, commit_size;
	logic               open_rej;
	logic [7:0]         open_beats;
	logic [31:0]        commit_seq;
	logic [2:0]         tail_bytes;
	logic [63:0]        byte_mask;
	logic [SW-1:0]      head_slot;

	assign req.ready = !back_busy && !q_valid && !q_full;
	assign take      = req.valid && req.ready;
	assign level     = head_q - tail_q;
	assign full      = (level == COUNT_W'(DEPTH));
	assign empty     = (level == '0);
	assign head_slot = head_q[SW-1:0];

	assign rd_seq  = seq_arr[rd_slot];
	assign rd_size = size_arr[rd_slot];

	always_comb begin
		pkt_sum  = 11'(HEADER_BYTES) + 11'(req.length);
		is_open  = take && (req.operation == OP_ENQ_PKT || req.operation == OP_ENQ_RAW);
		is_beat  = take && (req.operation == OP_BEAT);
		beat_ok  = is_beat && fill_pending_q && (beats_left_q != 8'd0);
		if (req.operation == OP_ENQ_PKT) begin
			open_size = (pkt_sum > 11'(MAX_PACKET_BYTES)) ? 10'(MAX_PACKET_BYTES)
				: pkt_sum[9:0];
			open_rej  = 1'b0;
		end else begin
			open_size = req.length;
			open_rej  = (11'(req.length) > 11'(MAX_PACKET_BYTES));
		end
		open_beats = 8'((11'(open_size) + 11'd7) >> 3);
		commit = (is_open && open_beats == 8'd0 && !open_rej)
			|| (beat_ok && beats_left_q == 8'd1 && !fill_rejected_q);
		commit_seq  = is_open ? req.seq : pending_seq_q;
		commit_size = is_open ? open_size : pending_size_q;

		// The final beat of a partial word keeps only the bytes inside the size.
		tail_bytes = pending_size_q[2:0];
		byte_mask  = '1;
		if (beats_left_q == 8'd1 && tail_bytes != 3'd0) begin
			byte_mask = (64'd1 << {tail_bytes, 3'b000}) - 64'd1;
		end
		ram_we    = beat_ok && !fill_rejected_q && (off_q < 8'(WPS));
		ram_waddr = AW'(AW'(head_slot) * AW'(WPS)) + AW'(off_q);
		ram_wdata = req.data_word & byte_mask;

		q_push = take && (req.operation == OP_DEQ || req.operation == OP_FIND);
		q_cmd.seq   = req.seq;
		q_cmd.count = level;
		if (req.operation == OP_FIND) begin
			q_cmd.kind = CMD_FIND;
			q_cmd.base = head_q;
		end else begin
			q_cmd.kind = empty ? CMD_EMPTY : CMD_EMIT;
			q_cmd.base = tail_q;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			seq_arr[head_slot]  <= commit_seq;
			size_arr[head_slot] <= commit_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q          <= '0;
			tail_q          <= '0;
			fill_pending_q  <= 1'b0;
			fill_rejected_q <= 1'b0;
			beats_left_q    <= 8'd0;
			off_q           <= 8'd0;
			pending_seq_q   <= 32'd0;
			pending_size_q  <= 10'd0;
		end else begin
			if (is_open) begin
				pending_seq_q   <= req.seq;
				pending_size_q  <= open_size;
				beats_left_q    <= open_beats;
				off_q           <= 8'd0;
				fill_pending_q  <= (open_beats != 8'd0);
				fill_rejected_q <= (open_beats != 8'd0) && open_rej;
			end else if (beat_ok) begin
				beats_left_q <= beats_left_q - 8'd1;
				off_q        <= off_q + 8'd1;
				if (beats_left_q == 8'd1) begin
					fill_pending_q  <= 1'b0;
					fill_rejected_q <= 1'b0;
				end
			end
			if (commit) begin
				head_q <= head_q + 1'b1;
			end
			if ((commit && full) || (q_push && req.operation == OP_DEQ && !empty)) begin
				tail_q <= tail_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/prdo_back.sv -----
`default_nettype none
module prdo_back #(
	parameter int unsigned DEPTH            = prdo_pkg::DEPTH_DEF,
	parameter int unsigned MAX_PACKET_BYTES = prdo_pkg::MAX_BYTES_DEF,
	localparam int unsigned WPS             = (MAX_PACKET_BYTES + 7) / 8,
	localparam int unsigned SW              = $clog2(DEPTH),
	localparam int unsigned AW              = $clog2(DEPTH * WPS)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire prdo_pkg::cmd_t q_cmd,
	output logic                q_pop,
	output logic                busy,
	output logic     [SW-1:0]   rd_slot,
	input  wire logic [31:0]    rd_seq,
	input  wire logic [9:0]     rd_size,
	output logic     [AW-1:0]   ram_raddr,
	input  wire logic [63:0]    ram_rdata,
	pr_rsp_if.source            rsp
);
	import prdo_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [31:0]        target_q;
	logic [COUNT_W-1:0] base_q, count_q, idx_q;
	logic [SW-1:0]      slot_q;
	logic [7:0]         k_q;

	logic               rd_s1, zero_s1, last_s1;
	logic [31:0]        seq_s1;
	logic [8:0]         size_s1;

	res_t               ent_q [2];
	logic               wr_q, rd_q;
	logic [1:0]         cnt_q;

	logic               pop, stat_ok, issue_ok, issue, stat_push, hit;
	logic [1:0]         stat_code;
	logic [COUNT_W-1:0] scan_pos;
	logic [7:0]         words_raw, words, n_words;
	logic [2:0]         room;
	res_t               push_ent;

	assign busy     = (state_q != ST_IDLE);
	assign pop      = rsp.valid && rsp.ready;
	assign stat_ok  = !rd_s1 && (cnt_q != 2'd2 || pop);
	assign room     = 3'd2 + {2'b00, pop} - {1'b0, cnt_q} - {2'b00, rd_s1};
	assign issue_ok = (room != 3'd0);
	assign scan_pos = base_q - COUNT_W'(1) - idx_q;

	always_comb begin
		rd_slot   = (state_q == ST_SCAN) ? scan_pos[SW-1:0] : slot_q;
		hit       = (rd_seq == target_q);
		words_raw = 8'((11'(rd_size) + 11'd7) >> 3);
		words     = (words_raw > 8'(WPS)) ? 8'(WPS) : words_raw;
		n_words   = (words == 8'd0) ? 8'd1 : words;
		ram_raddr = AW'(AW'(slot_q) * AW'(WPS)) + AW'(k_q);
		issue     = (state_q == ST_EMIT) && issue_ok;

		q_pop     = 1'b0;
		stat_push = 1'b0;
		stat_code = STAT_EMPTY;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_cmd.kind == CMD_EMPTY) begin
						q_pop     = stat_ok;
						stat_push = stat_ok;
					end else begin
						q_pop = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == count_q) begin
					stat_push = stat_ok;
					stat_code = STAT_NOTFOUND;
				end
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase

		if (rd_s1) begin
			push_ent.status   = STAT_WORD;
			push_ent.seq_out  = seq_s1;
			push_ent.size_out = size_s1;
			push_ent.word_out = zero_s1 ? 64'd0 : ram_rdata;
			push_ent.last     = last_s1;
		end else begin
			push_ent.status   = stat_code;
			push_ent.seq_out  = 32'd0;
			push_ent.size_out = 9'd0;
			push_ent.word_out = 64'd0;
			push_ent.last     = 1'b1;
		end
	end

	assign rsp.valid    = (cnt_q != 2'd0);
	assign rsp.status   = ent_q[rd_q].status;
	assign rsp.seq_out  = ent_q[rd_q].seq_out;
	assign rsp.size_out = ent_q[rd_q].size_out;
	assign rsp.word_out = ent_q[rd_q].word_out;
	assign rsp.last     = ent_q[rd_q].last;

	always_ff @(posedge clk) begin
		if (rd_s1 || stat_push) begin
			ent_q[wr_q] <= push_ent;
		end
		if (issue) begin
			seq_s1  <= rd_seq;
			size_s1 <= rd_size[8:0];
			zero_s1 <= (k_q >= words);
			last_s1 <= (9'(k_q) + 9'd1 == 9'(n_words));
		end
		if (q_pop && q_cmd.kind != CMD_EMPTY) begin
			target_q <= q_cmd.seq;
			base_q   <= q_cmd.base;
			count_q  <= q_cmd.count;
			slot_q   <= q_cmd.base[SW-1:0];
		end else if (state_q == ST_SCAN && idx_q != count_q && hit) begin
			slot_q <= scan_pos[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			k_q     <= 8'd0;
			rd_s1   <= 1'b0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			rd_s1 <= issue;
			if (rd_s1 || stat_push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, (rd_s1 || stat_push)} - {1'b0, pop};
			unique case (state_q)
				ST_IDLE: begin
					k_q   <= 8'd0;
					idx_q <= '0;
					if (q_pop && q_cmd.kind == CMD_EMIT) begin
						state_q <= ST_EMIT;
					end else if (q_pop && q_cmd.kind == CMD_FIND) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == count_q) begin
						if (stat_ok) begin
							state_q <= ST_IDLE;
						end
					end else if (hit) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						k_q <= k_q + 8'd1;
						if (k_q + 8'd1 == n_words) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/packet_ring_drop_oldest_seq_lookup_top.sv -----
`default_nettype none
// Enqueue, raw enqueue and data beat items go one per cycle while no read is pending.
// Dequeue and find hold the input until their last word has been read out of
// the payload RAM; words go one per cycle while the two-entry output buffer has room.
// A find first scans one stored sequence number per cycle, newest first (up to DEPTH).
// A dequeue's words pass the command queue, the EMIT state and the RAM read register.
// Reset clears the ring pointers and fill state; the slot stores need no clearing.
module packet_ring_drop_oldest_seq_lookup_top #(
	parameter int unsigned DEPTH            = prdo_pkg::DEPTH_DEF,
	parameter int unsigned MAX_PACKET_BYTES = prdo_pkg::MAX_BYTES_DEF,
	parameter int unsigned HEADER_BYTES     = prdo_pkg::HEADER_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pr_req_if.sink   req,
	pr_rsp_if.source rsp
);
	import prdo_pkg::*;

	localparam int unsigned WPS = (MAX_PACKET_BYTES + 7) / 8;
	localparam int unsigned SW  = $clog2(DEPTH);
	localparam int unsigned AW  = $clog2(DEPTH * WPS);

	logic          q_push, q_pop, q_valid, q_full, back_busy;
	cmd_t          push_cmd, head_cmd;
	logic [SW-1:0] rd_slot;
	logic [31:0]   rd_seq;
	logic [9:0]    rd_size;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;

	prdo_front #(
		.DEPTH(DEPTH), .MAX_PACKET_BYTES(MAX_PACKET_BYTES), .HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk, .arst_n, .req, .back_busy, .q_valid, .q_full,
		.q_push, .q_cmd(push_cmd), .rd_slot, .rd_seq, .rd_size,
		.ram_we, .ram_waddr, .ram_wdata
	);

	prdo_cmd_fifo u_cmdq (
		.clk, .arst_n, .push(q_push), .push_cmd, .pop(q_pop),
		.valid(q_valid), .full(q_full), .head_cmd
	);

	prdo_ram #(.WIDTH(64), .DEPTH(DEPTH * WPS)) u_words (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	prdo_back #(.DEPTH(DEPTH), .MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_back (
		.clk, .arst_n, .q_valid, .q_cmd(head_cmd), .q_pop, .busy(back_busy),
		.rd_slot, .rd_seq, .rd_size, .ram_raddr, .ram_rdata, .rsp
	);

endmodule
`default_nettype wire
